// ===== rtl/lsfit_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfit_pkg: shared constants and types for the least-squares line fit
// Sum widths, multiplier and divider sizes, operation codes, status codes and
// the command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lsfit_pkg;

  // Set limits and result format
  localparam int MAX_SAMPLES = 1024;
  localparam int FRAC_BITS   = 16;

  // Port widths fixed by the interface
  localparam int IN_W      = 16;
  localparam int OUT_W     = 48;
  localparam int CNT_OUT_W = 11;
  localparam int STAT_W    = 2;

  // Accumulator widths
  localparam int LG    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SX_W  = IN_W + LG;
  localparam int SXX_W = 2 * IN_W - 1 + LG;
  localparam int SXY_W = 2 * IN_W + LG;
  localparam int PRD_W = 2 * IN_W;

  // Shift-add multiplier: A magnitude, B magnitude (serial), product
  localparam int AM_W = SXX_W;
  localparam int BM_W = SX_W;
  localparam int PM_W = AM_W + BM_W;
  localparam int ACC_W = PM_W + 1;

  // Divider: denominator, iterations, kept quotient bits
  localparam int DEN_W     = 2 * IN_W - 1 + 2 * LG;
  localparam int DIV_STEPS = ACC_W + FRAC_BITS;
  localparam int QUO_W     = OUT_W + 1;

  // Sequencer step counter
  localparam int CTR_W = $clog2(DIV_STEPS + 2);

  // Product operations; odd codes subtract from the accumulator
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_N_SXX   = 3'd0;
  localparam logic [OP_W-1:0] OP_SX_SX   = 3'd1;
  localparam logic [OP_W-1:0] OP_N_SXY   = 3'd2;
  localparam logic [OP_W-1:0] OP_SX_SY   = 3'd3;
  localparam logic [OP_W-1:0] OP_SXX_SY  = 3'd4;
  localparam logic [OP_W-1:0] OP_SX_SXY  = 3'd5;

  // Fit status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEGEN = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic            take;
    logic            mul_load;
    logic            mul_step;
    logic [OP_W-1:0] op;
    logic            den_load;
    logic            div_load;
    logic            div_step;
    logic            div_save;
    logic            publish;
  } lsfit_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic acc_zero;
  } lsfit_sts_t;

endpackage

// ===== rtl/least_squares_line_fit.sv =====
// ----------------------------------------------------------------------------
// least_squares_line_fit: least-squares straight-line fit over sample sets
// Accumulates (x, y) pairs and, on the last sample of a set, returns slope
// and intercept in signed fixed point with count and fit status.
//
//   channel | signals                                   | transaction
//   --------+-------------------------------------------+---------------------
//   in      | in_valid_i, in_ready_o, x_value_i,        | one sample pair
//           | y_value_i, last_sample_i                  |
//   out     | out_valid_o, out_ready_i, slope_o,        | one fit result
//           | intercept_o, sample_count_o, fit_status_o |
//
// Samples are taken one per cycle while idle. After the last sample the
// block is busy: six products run on one bit-serial shift-add multiplier
// and two divisions on one restoring divider. A degenerate set stops
// after the denominator check. Samples are taken again while a result
// waits on a stalled output; the next fit waits for it to drain.
// Reset clears the sums, the count and the sequencer; nothing is swept.
// ----------------------------------------------------------------------------
module least_squares_line_fit
  import lsfit_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  x_value_i,
  input  logic signed [IN_W-1:0]  y_value_i,
  input  logic                    last_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] slope_o,
  output logic signed [OUT_W-1:0] intercept_o,
  output logic [CNT_OUT_W-1:0]    sample_count_o,
  output logic [STAT_W-1:0]       fit_status_o
);

  lsfit_cmd_t cmd;
  lsfit_sts_t sts;

  // Sequencer
  lsfit_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Sums, arithmetic and result register
  lsfit_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .x_value_i      (x_value_i),
    .y_value_i      (y_value_i),
    .slope_o        (slope_o),
    .intercept_o    (intercept_o),
    .sample_count_o (sample_count_o),
    .fit_status_o   (fit_status_o)
  );

endmodule

// ===== rtl/lsfit_div.sv =====
// ----------------------------------------------------------------------------
// lsfit_div: restoring divider, one quotient bit per cycle
// Divides an unsigned numerator magnitude, followed by FRAC_BITS zero bits,
// by the denominator; truncates, applies the sign and saturates to OUT_W bits.
// ----------------------------------------------------------------------------
module lsfit_div
  import lsfit_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic                    step_i,
  input  logic                    neg_i,
  input  logic [ACC_W-1:0]        num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic signed [OUT_W-1:0] quo_o,
  output logic                    sat_o
);

  localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W - 1){1'b0}}};

  logic [ACC_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] rem_d;
  logic [QUO_W-1:0] quo_q;
  logic             big_q;
  logic             neg_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             ge;
  logic [QUO_W-1:0] quo_neg;
  logic             pos_big;
  logic             neg_big;

  // Trial subtract of the shifted partial remainder
  assign rem_sh   = {rem_q, num_q[ACC_W-1]};
  assign ge       = rem_sh >= {1'b0, den_i};
  assign rem_diff = rem_sh - {1'b0, den_i};
  assign rem_d    = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  // Shift in numerator bits, then zeros for the fraction
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= num_i;
      rem_q <= '0;
      quo_q <= '0;
      big_q <= 1'b0;
      neg_q <= neg_i;
    end else if (step_i) begin
      num_q <= {num_q[ACC_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_W-2:0], ge};
      big_q <= big_q | quo_q[QUO_W-1];
    end
  end

  // Clamp the magnitude to the signed output range
  assign quo_neg = ~quo_q + QUO_W'(1);
  assign pos_big = big_q | quo_q[QUO_W-1] | quo_q[QUO_W-2];
  assign neg_big = big_q | quo_q[QUO_W-1] | (quo_q[QUO_W-2] & (|quo_q[QUO_W-3:0]));

  always_comb begin
    if (neg_q) begin
      sat_o = neg_big;
      quo_o = neg_big ? NEG_LIMIT : quo_neg[OUT_W-1:0];
    end else begin
      sat_o = pos_big;
      quo_o = pos_big ? POS_LIMIT : quo_q[OUT_W-1:0];
    end
  end

endmodule

// ===== rtl/lsfit_dp.sv =====
// ----------------------------------------------------------------------------
// lsfit_dp: sums, shift-add multiplier, divider and result registers
// Accumulates count and sums per sample through a product stage, forms the
// denominator and both numerators on a shared serial multiplier and divides.
// ----------------------------------------------------------------------------
module lsfit_dp
  import lsfit_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lsfit_cmd_t               cmd_i,
  output lsfit_sts_t               sts_o,
  input  logic signed [IN_W-1:0]   x_value_i,
  input  logic signed [IN_W-1:0]   y_value_i,
  output logic signed [OUT_W-1:0]  slope_o,
  output logic signed [OUT_W-1:0]  intercept_o,
  output logic [CNT_OUT_W-1:0]     sample_count_o,
  output logic [STAT_W-1:0]        fit_status_o
);

  // Product stage
  logic                    st_vld_q;
  logic signed [IN_W-1:0]  st_x_q;
  logic signed [IN_W-1:0]  st_y_q;
  logic [PRD_W-1:0]        st_xx_q;
  logic signed [PRD_W-1:0] st_xy_q;
  logic signed [PRD_W-1:0] prod_xx;
  logic signed [PRD_W-1:0] prod_xy;

  // Running sums
  logic [CNT_W-1:0]        count_q;
  logic signed [SX_W-1:0]  sum_x_q;
  logic signed [SX_W-1:0]  sum_y_q;
  logic [SXX_W-1:0]        sum_xx_q;
  logic signed [SXY_W-1:0] sum_xy_q;
  logic                    ovf_q;

  // Multiplier and accumulator
  logic [SX_W-1:0]   sx_mag;
  logic [SX_W-1:0]   sy_mag;
  logic [SXY_W-1:0]  sxy_mag;
  logic [AM_W-1:0]   op_a;
  logic              op_sa;
  logic [BM_W-1:0]   op_b;
  logic              op_sb;
  logic [PM_W-1:0]   a_sh_q;
  logic [BM_W-1:0]   b_q;
  logic              neg_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  a_ext;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  acc_mag;

  // Fit results
  logic [DEN_W-1:0]        den_q;
  logic                    degen_q;
  logic                    sat_q;
  logic signed [OUT_W-1:0] slope_res_q;
  logic signed [OUT_W-1:0] quo;
  logic                    quo_sat;
  logic signed [OUT_W-1:0] slope_q;
  logic signed [OUT_W-1:0] icpt_q;
  logic [CNT_OUT_W-1:0]    cnt_out_q;
  logic [STAT_W-1:0]       status_q;
  logic [STAT_W-1:0]       status_d;

  // Register the sample and its products
  assign prod_xx = x_value_i * x_value_i;
  assign prod_xy = x_value_i * y_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= cmd_i.take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      st_x_q  <= x_value_i;
      st_y_q  <= y_value_i;
      st_xx_q <= prod_xx;
      st_xy_q <= prod_xy;
    end
  end

  // Accumulate while room is left, flag extra samples, clear on publish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_xy_q <= '0;
      ovf_q    <= 1'b0;
    end else if (cmd_i.publish) begin
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_xy_q <= '0;
      ovf_q    <= 1'b0;
    end else if (st_vld_q) begin
      if (count_q < CNT_W'(MAX_SAMPLES)) begin
        count_q  <= count_q + CNT_W'(1);
        sum_x_q  <= sum_x_q + SX_W'(st_x_q);
        sum_y_q  <= sum_y_q + SX_W'(st_y_q);
        sum_xx_q <= sum_xx_q + SXX_W'(st_xx_q);
        sum_xy_q <= sum_xy_q + SXY_W'(st_xy_q);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // Magnitudes of the signed sums
  assign sx_mag  = sum_x_q[SX_W-1]   ? (~sum_x_q + SX_W'(1))   : sum_x_q;
  assign sy_mag  = sum_y_q[SX_W-1]   ? (~sum_y_q + SX_W'(1))   : sum_y_q;
  assign sxy_mag = sum_xy_q[SXY_W-1] ? (~sum_xy_q + SXY_W'(1)) : sum_xy_q;

  // Select the operand pair of the current product
  always_comb begin
    case (cmd_i.op)
      OP_N_SXX: begin
        op_a = sum_xx_q;               op_sa = 1'b0;
        op_b = BM_W'(count_q);         op_sb = 1'b0;
      end
      OP_SX_SX: begin
        op_a = AM_W'(sx_mag);          op_sa = 1'b0;
        op_b = sx_mag;                 op_sb = 1'b0;
      end
      OP_N_SXY: begin
        op_a = sxy_mag[AM_W-1:0];      op_sa = sum_xy_q[SXY_W-1];
        op_b = BM_W'(count_q);         op_sb = 1'b0;
      end
      OP_SX_SY: begin
        op_a = AM_W'(sy_mag);          op_sa = sum_y_q[SX_W-1];
        op_b = sx_mag;                 op_sb = sum_x_q[SX_W-1];
      end
      OP_SXX_SY: begin
        op_a = sum_xx_q;               op_sa = 1'b0;
        op_b = sy_mag;                 op_sb = sum_y_q[SX_W-1];
      end
      OP_SX_SXY: begin
        op_a = sxy_mag[AM_W-1:0];      op_sa = sum_xy_q[SXY_W-1];
        op_b = sx_mag;                 op_sb = sum_x_q[SX_W-1];
      end
      default: begin
        op_a = '0;                     op_sa = 1'b0;
        op_b = '0;                     op_sb = 1'b0;
      end
    endcase
  end

  // Add or subtract the shifted multiplicand for each set multiplier bit
  assign a_ext  = ACC_W'(a_sh_q);
  assign addend = neg_q ? (~a_ext + ACC_W'(1)) : a_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      a_sh_q <= PM_W'(op_a);
      b_q    <= op_b;
      // odd operations subtract from the first product of the pair
      neg_q  <= op_sa ^ op_sb ^ cmd_i.op[0];
      if (!cmd_i.op[0]) begin
        acc_q <= '0;
      end
    end else if (cmd_i.mul_step) begin
      a_sh_q <= {a_sh_q[PM_W-2:0], 1'b0};
      b_q    <= {1'b0, b_q[BM_W-1:1]};
      if (b_q[0]) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  assign sts_o.acc_zero = (acc_q == '0);

  // Hold denominator and per-fit flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.den_load) begin
      den_q   <= acc_q[DEN_W-1:0];
      degen_q <= (acc_q == '0);
      sat_q   <= 1'b0;
    end else if (cmd_i.div_save) begin
      sat_q <= sat_q | quo_sat;
    end
    if (cmd_i.div_save) begin
      slope_res_q <= quo;
    end
  end

  // Divide the accumulated numerator by the denominator
  assign acc_mag = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;

  lsfit_div u_div (
    .clk_i  (clk_i),
    .load_i (cmd_i.div_load),
    .step_i (cmd_i.div_step),
    .neg_i  (acc_q[ACC_W-1]),
    .num_i  (acc_mag),
    .den_i  (den_q),
    .quo_o  (quo),
    .sat_o  (quo_sat)
  );

  // Resolve status: degenerate over too many samples over saturated
  always_comb begin
    if (degen_q) begin
      status_d = ST_DEGEN;
    end else if (ovf_q) begin
      status_d = ST_OVF;
    end else if (sat_q || quo_sat) begin
      status_d = ST_SAT;
    end else begin
      status_d = ST_OK;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      slope_q   <= degen_q ? '0 : slope_res_q;
      icpt_q    <= degen_q ? '0 : quo;
      cnt_out_q <= CNT_OUT_W'(count_q);
      status_q  <= status_d;
    end
  end

  assign slope_o        = slope_q;
  assign intercept_o    = icpt_q;
  assign sample_count_o = cnt_out_q;
  assign fit_status_o   = status_q;

endmodule

// ===== rtl/lsfit_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsfit_ctrl: sequencer for the line fit
// Takes samples while idle and steps the datapath through up to six products,
// the denominator check, up to two divisions and the result transaction.
// ----------------------------------------------------------------------------
module lsfit_ctrl
  import lsfit_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       last_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  lsfit_sts_t sts_i,
  output lsfit_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DEN   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_PUB   = 3'd5;

  logic [2:0]       state_q;
  logic [2:0]       state_d;
  logic [OP_W-1:0]  op_q;
  logic [OP_W-1:0]  op_d;
  logic [CTR_W-1:0] cnt_q;
  logic [CTR_W-1:0] cnt_d;
  logic             out_valid_q;
  logic             out_valid_d;
  lsfit_cmd_t       cmd;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    cmd        = '0;
    cmd.op     = op_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.take = 1'b1;
          if (last_sample_i) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // let the product stage add the final sample
        state_d = S_MUL;
        op_d    = OP_N_SXX;
        cnt_d   = '0;
      end
      S_MUL: begin
        if (cnt_q == '0) begin
          cmd.mul_load = 1'b1;
        end else begin
          cmd.mul_step = 1'b1;
        end
        if (cnt_q == CTR_W'(BM_W)) begin
          cnt_d = '0;
          if (op_q == OP_SX_SX) begin
            state_d = S_DEN;
          end else if (op_q inside {OP_SX_SY, OP_SX_SXY}) begin
            state_d = S_DIV;
          end else begin
            op_d = op_q + OP_W'(1);
          end
        end else begin
          cnt_d = cnt_q + CTR_W'(1);
        end
      end
      S_DEN: begin
        cmd.den_load = 1'b1;
        if (sts_i.acc_zero) begin
          state_d = S_PUB;
        end else begin
          state_d = S_MUL;
          op_d    = OP_N_SXY;
        end
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          cmd.div_load = 1'b1;
          cnt_d        = cnt_q + CTR_W'(1);
        end else if (cnt_q == CTR_W'(DIV_STEPS + 1)) begin
          cnt_d = '0;
          if (op_q == OP_SX_SY) begin
            cmd.div_save = 1'b1;
            state_d      = S_MUL;
            op_d         = OP_SXX_SY;
          end else begin
            state_d = S_PUB;
          end
        end else begin
          cmd.div_step = 1'b1;
          cnt_d        = cnt_q + CTR_W'(1);
        end
      end
      S_PUB: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd.publish = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until its transaction completes
  assign out_valid_d = cmd.publish | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_N_SXX;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ===== tb/sv/lsfit_result_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsfit_result_check: result checker for the least-squares line fit
// Watches both channels and keeps its own count and sums of x, y, x*x and
// x*y. When it sees the sample marked last, it works out the expected fit.
// Each result that comes back is compared field by field with the oldest
// expected fit. The counts go back to the testbench top.
// ----------------------------------------------------------------------------
module lsfit_result_check
  import lsfit_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [IN_W-1:0]  x_value_i,
  input  logic signed [IN_W-1:0]  y_value_i,
  input  logic                    last_sample_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [OUT_W-1:0] slope_i,
  input  logic signed [OUT_W-1:0] intercept_i,
  input  logic [CNT_OUT_W-1:0]    sample_count_i,
  input  logic [STAT_W-1:0]       fit_status_i,
  output int                      mismatch_count_o,
  output int                      pending_o,
  output int                      sample_total_o,
  output int                      fit_total_o,
  output int                      degenerate_total_o,
  output int                      overflow_total_o
);

  localparam int REPORT_LIMIT = 10;

  // Bounds of the signed result field, widened to the quotient width
  localparam logic signed [127:0] QUO_HI = {{(129 - OUT_W){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [127:0] QUO_LO = {{(129 - OUT_W){1'b1}}, {(OUT_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic [CNT_OUT_W-1:0]    count;
    logic [STAT_W-1:0]       status;
  } fit_result_t;

  // Running sums of the set being collected
  int     acc_n;
  longint acc_sx;
  longint acc_sy;
  longint acc_sxx;
  longint acc_sxy;
  bit     acc_ovf;

  fit_result_t expected_fits[$];
  fit_result_t got;
  fit_result_t want;
  int          mismatches;
  int          samples;
  int          fits;
  int          degenerate;
  int          overflowed;

  task automatic clear_sums();
    acc_n   = 0;
    acc_sx  = 0;
    acc_sy  = 0;
    acc_sxx = 0;
    acc_sxy = 0;
    acc_ovf = 1'b0;
  endtask

  // Clamp a quotient to the result field and note a saturation
  function automatic logic signed [OUT_W-1:0] clamp_quotient(
    input logic signed [127:0] q,
    inout bit                  sat
  );
    if (q > QUO_HI) begin
      sat = 1'b1;
      return QUO_HI[OUT_W-1:0];
    end
    if (q < QUO_LO) begin
      sat = 1'b1;
      return QUO_LO[OUT_W-1:0];
    end
    return q[OUT_W-1:0];
  endfunction

  // Exact least-squares fit over the current sums, truncated toward zero
  function automatic fit_result_t solve_fit();
    logic signed [127:0] n_w;
    logic signed [127:0] sx_w;
    logic signed [127:0] sy_w;
    logic signed [127:0] sxx_w;
    logic signed [127:0] sxy_w;
    logic signed [127:0] den;
    logic signed [127:0] num_s;
    logic signed [127:0] num_i;
    fit_result_t         r;
    bit                  sat;
    n_w   = 128'(acc_n);
    sx_w  = 128'(acc_sx);
    sy_w  = 128'(acc_sy);
    sxx_w = 128'(acc_sxx);
    sxy_w = 128'(acc_sxy);
    sat   = 1'b0;
    den   = n_w * sxx_w - sx_w * sx_w;
    r.count = acc_n[CNT_OUT_W-1:0];
    if (acc_n == 0 || den == 0) begin
      r.slope     = '0;
      r.intercept = '0;
      r.status    = ST_DEGEN;
    end else begin
      num_s = (n_w * sxy_w - sx_w * sy_w) <<< FRAC_BITS;
      num_i = (sxx_w * sy_w - sx_w * sxy_w) <<< FRAC_BITS;
      r.slope     = clamp_quotient(num_s / den, sat);
      r.intercept = clamp_quotient(num_i / den, sat);
      if (acc_ovf)
        r.status = ST_OVF;
      else if (sat)
        r.status = ST_SAT;
      else
        r.status = ST_OK;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sums();
      expected_fits.delete();
      mismatches = 0;
      samples    = 0;
      fits       = 0;
      degenerate = 0;
      overflowed = 0;
    end else begin
      // Compare a result transaction with the oldest expected fit
      if (out_valid_i && out_ready_i) begin
        got.slope     = slope_i;
        got.intercept = intercept_i;
        got.count     = sample_count_i;
        got.status    = fit_status_i;
        if (expected_fits.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected fit result: slope %0d intercept %0d count %0d status %0d",
                     $signed(got.slope), $signed(got.intercept), got.count, got.status);
        end else begin
          want = expected_fits.pop_front();
          fits++;
          if (want.status == ST_DEGEN) degenerate++;
          if (want.status == ST_OVF) overflowed++;
          if (got.slope !== want.slope || got.intercept !== want.intercept ||
              got.count !== want.count || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("fit %0d wrong (expected/actual): slope %0d/%0d intercept %0d/%0d %s",
                       fits, $signed(want.slope), $signed(got.slope),
                       $signed(want.intercept), $signed(got.intercept),
                       $sformatf("count %0d/%0d status %0d/%0d",
                                 want.count, got.count, want.status, got.status));
          end
        end
      end

      // Accumulate a sample transaction; keep only the first MAX_SAMPLES
      if (in_valid_i && in_ready_i) begin
        samples++;
        if (acc_n < MAX_SAMPLES) begin
          acc_n++;
          acc_sx  += longint'(x_value_i);
          acc_sy  += longint'(y_value_i);
          acc_sxx += longint'(x_value_i) * longint'(x_value_i);
          acc_sxy += longint'(x_value_i) * longint'(y_value_i);
        end else begin
          acc_ovf = 1'b1;
        end
        if (last_sample_i) begin
          expected_fits.insert(expected_fits.size(), solve_fit());
          clear_sums();
        end
      end
    end
    mismatch_count_o   <= mismatches;
    pending_o          <= expected_fits.size();
    sample_total_o     <= samples;
    fit_total_o        <= fits;
    degenerate_total_o <= degenerate;
    overflow_total_o   <= overflowed;
  end

endmodule

// ===== tb/sv/tb_least_squares_line_fit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_least_squares_line_fit: testbench top for the least-squares line fit
// First come short directed sets: a single sample, constant x, full-scale
// values and results that truncate. Then come random sets of several shapes,
// one of them longer than the sample limit. Samples go in bursts with random
// gaps, and the result side stalls on rotating patterns. lsfit_result_check
// does the checking, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_least_squares_line_fit;
  import lsfit_pkg::*;

  localparam int RANDOM_SAMPLES = 2000;
  localparam int CYCLE_LIMIT    = 10_000_000;
  localparam int DRAIN_CYCLES   = 400;

  localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W - 1){1'b1}}};
  localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W - 1){1'b0}}};

  typedef enum int {SET_FLAT_X, SET_EXTREME, SET_SMALL, SET_LINEAR, SET_WIDE} set_shape_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic signed [IN_W-1:0]  x_value     = '0;
  logic signed [IN_W-1:0]  y_value     = '0;
  logic                    last_sample = 1'b0;
  logic                    out_ready   = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [OUT_W-1:0] slope;
  logic signed [OUT_W-1:0] intercept;
  logic [CNT_OUT_W-1:0]    sample_count;
  logic [STAT_W-1:0]       fit_status;

  rx_mode_e    rx_mode     = RX_OPEN;
  int unsigned cycle_count = 0;
  int          burst_left  = 0;
  int          sent_count  = 0;

  int mismatch_count;
  int pending;
  int sample_total;
  int fit_total;
  int degenerate_total;
  int overflow_total;

  least_squares_line_fit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .x_value_i      (x_value),
    .y_value_i      (y_value),
    .last_sample_i  (last_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .slope_o        (slope),
    .intercept_o    (intercept),
    .sample_count_o (sample_count),
    .fit_status_o   (fit_status)
  );

  lsfit_result_check result_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .x_value_i          (x_value),
    .y_value_i          (y_value),
    .last_sample_i      (last_sample),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .slope_i            (slope),
    .intercept_i        (intercept),
    .sample_count_i     (sample_count),
    .fit_status_i       (fit_status),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending),
    .sample_total_o     (sample_total),
    .fit_total_o        (fit_total),
    .degenerate_total_o (degenerate_total),
    .overflow_total_o   (overflow_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Count cycles and stall the result side on a randomly chosen pattern
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 128 == 0) rx_mode <= rx_mode_e'(2'($urandom_range(0, 3)));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= cycle_count[4];
    endcase
  end

  // Drive one sample and hold it until accepted; idle between bursts
  task automatic send_sample(
    input logic signed [IN_W-1:0] xv,
    input logic signed [IN_W-1:0] yv,
    input logic                   lst
  );
    int gap;
    int pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 15);
      if (pick < 4)
        gap = 0;
      else if (pick == 15)
        gap = $urandom_range(50, 400);
      else
        gap = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid    <= 1'b1;
    x_value     <= xv;
    y_value     <= yv;
    last_sample <= lst;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_count++;
  endtask

  // Send one complete set of the given length and shape
  task automatic send_set(input int len, input set_shape_e shape);
    logic signed [IN_W-1:0] base_x;
    logic signed [IN_W-1:0] xv;
    logic signed [IN_W-1:0] yv;
    int                     k;
    int                     offset;
    int                     xi;
    base_x = IN_W'($urandom);
    k      = $urandom_range(0, 30) - 15;
    offset = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < len; i++) begin
      case (shape)
        SET_FLAT_X: begin
          xv = base_x;
          yv = IN_W'($urandom);
        end
        SET_EXTREME: begin
          xv = ($urandom_range(0, 1) != 0) ? IN_MAX : IN_MIN;
          yv = ($urandom_range(0, 1) != 0) ? IN_MAX : IN_MIN;
        end
        SET_SMALL: begin
          xv = IN_W'(int'($urandom_range(0, 16)) - 8);
          yv = IN_W'(int'($urandom_range(0, 64)) - 32);
        end
        SET_LINEAR: begin
          xi = $urandom_range(0, 2048) - 1024;
          xv = IN_W'(xi);
          yv = IN_W'(xi * k + offset + int'($urandom_range(0, 6)) - 3);
        end
        default: begin
          xv = IN_W'($urandom);
          yv = IN_W'($urandom);
        end
      endcase
      send_sample(xv, yv, i == len - 1);
    end
  endtask

  initial begin
    int         random_start;
    int         len;
    int         pick;
    bit         long_done;
    set_shape_e shape;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Single sample: degenerate
    send_sample(16'sd5, -16'sd7, 1'b1);
    // Constant x: degenerate
    send_sample(-16'sd300, 16'sd1, 1'b0);
    send_sample(-16'sd300, 16'sd2, 1'b0);
    send_sample(-16'sd300, -16'sd9, 1'b1);
    // Steepest slope at the most negative x: intercept near the lower bound
    send_sample(IN_MIN, IN_MAX, 1'b0);
    send_sample(IN_MIN + 16'sd1, IN_MIN, 1'b1);
    // Steepest slope at the most positive x: large positive intercept
    send_sample(IN_MAX - 16'sd1, IN_MAX, 1'b0);
    send_sample(IN_MAX, IN_MIN, 1'b1);
    // Full-scale diagonal
    send_sample(IN_MAX, IN_MAX, 1'b0);
    send_sample(IN_MIN, IN_MIN, 1'b0);
    send_sample(16'sd0, 16'sd1, 1'b1);
    // Fractional negative results: truncate toward zero
    send_sample(16'sd1, -16'sd1, 1'b0);
    send_sample(16'sd2, -16'sd3, 1'b0);
    send_sample(16'sd4, -16'sd4, 1'b1);
    // Exact line y = 3x - 5
    send_sample(16'sd0, -16'sd5, 1'b0);
    send_sample(16'sd2, 16'sd1, 1'b0);
    send_sample(-16'sd4, -16'sd17, 1'b0);
    send_sample(16'sd10, 16'sd25, 1'b1);

    // Random sets, mostly short; one set runs past the sample limit
    random_start = sent_count;
    long_done    = 1'b0;
    while (sent_count - random_start < RANDOM_SAMPLES) begin
      if (!long_done && sent_count - random_start > 400) begin
        send_set(MAX_SAMPLES + $urandom_range(1, 4), SET_EXTREME);
        long_done = 1'b1;
      end else begin
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        pick = $urandom_range(0, 9);
        if (pick < 1)
          shape = SET_FLAT_X;
        else if (pick < 3)
          shape = SET_EXTREME;
        else if (pick < 5)
          shape = SET_SMALL;
        else if (pick < 7)
          shape = SET_LINEAR;
        else
          shape = SET_WIDE;
        send_set(len, shape);
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding fits, then give stray results time to show
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples in %0d fits: %0d degenerate, %0d past the sample limit.",
             sample_total, fit_total, degenerate_total, overflow_total);
    $display("Samples came in random bursts; the result side stalled on rotating patterns.");
    if (mismatch_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
